@@ src/wmlb_pkg.sv @@
// Shared types and constants of the weighted map load balancer.
package wmlb_pkg;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 4;
  localparam int WGT_W   = 9;
  localparam int MASK_W  = 16;
  localparam int AVOID_W = 5;
  localparam int HASH_W  = 32;
  localparam int SRV_W   = 4;
  localparam int LEN_W   = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET       = 2'd0,
    CMD_REBUILD   = 2'd1,
    CMD_RR_PICK   = 2'd2,
    CMD_HASH_PICK = 2'd3
  } cmd_t;

  typedef struct packed {
    logic load_item;
    logic set_entry;
    logic res_clear;
    logic sum_clear;
    logic sum_step;
    logic prep;
    logic scan_step;
    logic slot_commit;
    logic rr_start;
    logic rr_read;
    logic rr_check;
    logic div_start;
    logic div_step;
    logic hash_read;
    logic res_hash;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd_code;
    logic total_zero;
    logic sum_last;
    logic none_eligible;
    logic scan_last;
    logic slot_last;
    logic rr_stop;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/wmlb_req_if.sv @@
// Request channel: valid/ready handshake with the command item.
interface wmlb_req_if;
  logic                        valid;
  logic                        ready;
  logic [wmlb_pkg::CMD_W-1:0]   command;
  logic [wmlb_pkg::IDX_W-1:0]   server_index;
  logic [wmlb_pkg::WGT_W-1:0]   weight;
  logic                        backup;
  logic                        usable;
  logic [wmlb_pkg::MASK_W-1:0]  available_mask;
  logic [wmlb_pkg::AVOID_W-1:0] avoid_index;
  logic [wmlb_pkg::HASH_W-1:0]  hash;

  modport source (
    output valid, command, server_index, weight, backup, usable, available_mask,
           avoid_index, hash,
    input  ready
  );
  modport sink (
    input  valid, command, server_index, weight, backup, usable, available_mask,
           avoid_index, hash,
    output ready
  );
endinterface

@@ src/wmlb_rsp_if.sv @@
// Result channel: valid/ready handshake with the pick result.
interface wmlb_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      chosen_valid;
  logic [wmlb_pkg::SRV_W-1:0] chosen_server;
  logic                      chosen_is_avoided;
  logic [wmlb_pkg::LEN_W-1:0] map_length;

  modport source (
    output valid, chosen_valid, chosen_server, chosen_is_avoided, map_length,
    input  ready
  );
  modport sink (
    input  valid, chosen_valid, chosen_server, chosen_is_avoided, map_length,
    output ready
  );
endinterface

@@ src/wmlb_datapath.sv @@
// Datapath: server table, slot map memory, score, walk and modulo registers.
module wmlb_datapath #(
  parameter int SERVERS    = 16,
  parameter int MAX_WEIGHT = 256,
  parameter int MAP_DEPTH  = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [wmlb_pkg::CMD_W-1:0]   command,
  input  logic [wmlb_pkg::IDX_W-1:0]   server_index,
  input  logic [wmlb_pkg::WGT_W-1:0]   weight,
  input  logic                         backup,
  input  logic                         usable,
  input  logic [wmlb_pkg::MASK_W-1:0]  available_mask,
  input  logic [wmlb_pkg::AVOID_W-1:0] avoid_index,
  input  logic [wmlb_pkg::HASH_W-1:0]  hash,
  input  wmlb_pkg::dp_cmd_t            cmd,
  output wmlb_pkg::dp_status_t         status,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_chosen_valid,
  output logic [wmlb_pkg::SRV_W-1:0]   out_chosen_server,
  output logic                         out_chosen_is_avoided,
  output logic [wmlb_pkg::LEN_W-1:0]   out_map_length
);

  localparam int SW   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int WW   = $clog2(MAX_WEIGHT + 1);
  localparam int TW   = $clog2(MAP_DEPTH + 1);
  localparam int AW   = $clog2(MAP_DEPTH);
  localparam int SUMW = $clog2(SERVERS * MAX_WEIGHT + 1);
  localparam int QW   = $clog2(MAP_DEPTH * MAX_WEIGHT + 2);
  localparam int RSW  = (TW > WW) ? TW : WW;
  localparam int RW   = RSW + 1;
  localparam int XW   = (SW > 5) ? SW : 5;
  localparam int DCW  = $clog2(wmlb_pkg::HASH_W);

  // captured item
  wmlb_pkg::cmd_t                 it_cmd;
  logic [wmlb_pkg::IDX_W-1:0]     it_idx;
  logic [wmlb_pkg::WGT_W-1:0]     it_weight;
  logic                           it_backup;
  logic                           it_usable;
  logic [wmlb_pkg::MASK_W-1:0]    it_mask;
  logic [wmlb_pkg::AVOID_W-1:0]   it_avoid;
  logic [wmlb_pkg::HASH_W-1:0]    it_hash;

  // server table
  logic [WW-1:0] tbl_w [SERVERS];
  logic          tbl_b [SERVERS];
  logic          tbl_u [SERVERS];

  // coarse score kept as quotient and remainder of (score + total) / total
  logic [QW-1:0]  q [SERVERS];
  logic [RSW-1:0] r [SERVERS];

  logic [SUMW-1:0] act_w, bck_w;
  logic            act_any, bck_any;
  logic            cls;
  logic [TW-1:0]   total_in_use;
  logic [TW-1:0]   rot;
  logic [SW-1:0]   srv_cnt;
  logic [TW-1:0]   slot;
  logic [SW-1:0]   best;
  logic [QW-1:0]   best_q;
  logic            best_found;
  logic            pending;

  logic [TW-1:0]   pos, start, av_next;
  logic            found_av;
  logic [SW-1:0]   av_srv;
  logic [TW-1:0]   rem;
  logic [DCW-1:0]  div_cnt;

  logic [SW-1:0]   map_mem [MAP_DEPTH];
  logic [SW-1:0]   map_rd;

  logic                          res_valid;
  logic [wmlb_pkg::SRV_W-1:0]    res_server;
  logic                          res_avoided;

  // table lookup at the server counter
  logic [WW-1:0]   w_cur;
  logic            elig_cur, in_class, srv_last, tot_one;
  logic [RW-1:0]   addend, rsum, rsub, tot_rw;
  logic            over1, over2, scan_more;
  logic [QW-1:0]   q_new;

  always_comb begin
    w_cur    = tbl_w[srv_cnt];
    elig_cur = tbl_u[srv_cnt] && (w_cur != '0);
    in_class = elig_cur && (tbl_b[srv_cnt] == cls);
    srv_last = (srv_cnt == SW'(SERVERS - 1));
    tot_one  = (total_in_use == TW'(1));
    addend   = pending ? '0 : RW'(w_cur);
    rsum     = RW'(r[srv_cnt]) + addend;
    tot_rw   = RW'(total_in_use);
    over1    = (rsum >= tot_rw);
    rsub     = rsum - tot_rw;
    over2    = over1 && (rsub >= tot_rw);
    q_new    = over1 ? q[srv_cnt] + QW'(1) : q[srv_cnt];
    scan_more = in_class && !tot_one && over2;
  end

  // rebuild total
  logic [SUMW-1:0] sum_sel;
  logic [TW-1:0]   tot_cap;

  always_comb begin
    sum_sel = act_any ? act_w : bck_w;
    tot_cap = (int'(sum_sel) > MAP_DEPTH) ? TW'(MAP_DEPTH) : TW'(sum_sel);
  end

  // round-robin walk
  logic [XW-1:0] srv_x;
  logic [TW-1:0] pos_inc, posn;
  logic          avail, av_now, hit, walk_end, fin_found;
  logic [TW-1:0] fin_next;
  logic [SW-1:0] fin_srv;

  always_comb begin
    srv_x     = XW'(map_rd);
    avail     = (srv_x < XW'(16)) && it_mask[srv_x[3:0]];
    av_now    = avail && (srv_x == XW'(it_avoid));
    hit       = avail && !av_now;
    pos_inc   = pos + TW'(1);
    posn      = (pos_inc == total_in_use) ? '0 : pos_inc;
    walk_end  = (posn == start);
    fin_found = found_av || av_now;
    fin_next  = av_now ? posn : av_next;
    fin_srv   = av_now ? map_rd : av_srv;
  end

  // hash modulo, one bit per cycle
  logic [TW:0] div_sh;

  always_comb begin
    div_sh = {rem, it_hash[div_cnt]};
  end

  always_comb begin
    status.cmd_code      = it_cmd;
    status.total_zero    = (total_in_use == '0);
    status.sum_last      = srv_last;
    status.none_eligible = !(act_any || bck_any);
    status.scan_last     = srv_last && !scan_more;
    status.slot_last     = (slot == total_in_use - TW'(1));
    status.rr_stop       = hit || walk_end;
    status.div_last      = (div_cnt == '0);
    status.out_free      = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_cmd    <= wmlb_pkg::cmd_t'(command);
      it_idx    <= server_index;
      it_weight <= weight;
      it_backup <= backup;
      it_usable <= usable;
      it_mask   <= available_mask;
      it_avoid  <= avoid_index;
      it_hash   <= hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SERVERS; i++) begin
        tbl_w[i] <= '0;
        tbl_b[i] <= 1'b0;
        tbl_u[i] <= 1'b0;
      end
    end else if (cmd.set_entry && (int'(it_idx) < SERVERS)) begin
      tbl_w[SW'(it_idx)] <= (it_weight > wmlb_pkg::WGT_W'(MAX_WEIGHT)) ?
                            WW'(MAX_WEIGHT) : WW'(it_weight);
      tbl_b[SW'(it_idx)] <= it_backup;
      tbl_u[SW'(it_idx)] <= it_usable;
    end
  end

  // rebuild control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_in_use <= '0;
      srv_cnt      <= '0;
      pending      <= 1'b0;
      best_found   <= 1'b0;
    end else begin
      if (cmd.sum_clear) begin
        act_w   <= '0;
        bck_w   <= '0;
        act_any <= 1'b0;
        bck_any <= 1'b0;
        srv_cnt <= '0;
      end
      if (cmd.sum_step) begin
        if (elig_cur) begin
          if (tbl_b[srv_cnt]) begin
            bck_w   <= bck_w + SUMW'(w_cur);
            bck_any <= 1'b1;
          end else begin
            act_w   <= act_w + SUMW'(w_cur);
            act_any <= 1'b1;
          end
        end
        srv_cnt <= srv_last ? '0 : srv_cnt + SW'(1);
      end
      if (cmd.prep) begin
        cls          <= !act_any;
        total_in_use <= (act_any || bck_any) ? tot_cap : '0;
        slot         <= '0;
        srv_cnt      <= '0;
        best_found   <= 1'b0;
        pending      <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (in_class) begin
          if (tot_one) begin
            if (!best_found) begin
              best       <= srv_cnt;
              best_found <= 1'b1;
            end
          end else if (!over2 && (!best_found || (q_new > best_q))) begin
            best       <= srv_cnt;
            best_q     <= q_new;
            best_found <= 1'b1;
          end
        end
        if (scan_more) begin
          pending <= 1'b1;
        end else begin
          pending <= 1'b0;
          srv_cnt <= srv_last ? '0 : srv_cnt + SW'(1);
        end
      end
      if (cmd.slot_commit) begin
        slot       <= slot + TW'(1);
        srv_cnt    <= '0;
        best_found <= 1'b0;
        pending    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      for (int i = 0; i < SERVERS; i++) begin
        q[i] <= QW'(1);
        r[i] <= '0;
      end
    end else if (cmd.scan_step && in_class && !tot_one) begin
      q[srv_cnt] <= q_new;
      r[srv_cnt] <= over1 ? RSW'(rsub) : RSW'(rsum);
    end else if (cmd.slot_commit && best_found && !tot_one) begin
      q[best] <= q[best] - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_commit) begin
      map_mem[slot[AW-1:0]] <= best_found ? best : '0;
    end
    if (cmd.rr_read) begin
      map_rd <= map_mem[pos[AW-1:0]];
    end else if (cmd.hash_read) begin
      map_rd <= map_mem[rem[AW-1:0]];
    end
  end

  // pick registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot <= '0;
    end else begin
      if (cmd.rr_start) begin
        start    <= (rot < total_in_use) ? rot : '0;
        pos      <= (rot < total_in_use) ? rot : '0;
        found_av <= 1'b0;
      end
      if (cmd.rr_check) begin
        if (hit) begin
          rot <= posn;
        end else if (walk_end) begin
          if (fin_found) begin
            rot <= fin_next;
          end
        end else begin
          pos      <= posn;
          found_av <= fin_found;
          av_next  <= fin_next;
          av_srv   <= fin_srv;
        end
      end
      if (cmd.div_start) begin
        rem     <= '0;
        div_cnt <= DCW'(wmlb_pkg::HASH_W - 1);
      end
      if (cmd.div_step) begin
        rem     <= (div_sh >= (TW + 1)'(total_in_use)) ?
                   TW'(div_sh - (TW + 1)'(total_in_use)) : TW'(div_sh);
        div_cnt <= div_cnt - DCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      res_valid   <= 1'b0;
      res_server  <= '0;
      res_avoided <= 1'b0;
    end
    if (cmd.rr_check) begin
      if (hit) begin
        res_valid  <= 1'b1;
        res_server <= srv_x[3:0];
      end else if (walk_end && fin_found) begin
        res_valid   <= 1'b1;
        res_server  <= wmlb_pkg::SRV_W'(XW'(fin_srv));
        res_avoided <= 1'b1;
      end
    end
    if (cmd.res_hash) begin
      res_valid  <= 1'b1;
      res_server <= wmlb_pkg::SRV_W'(XW'(map_rd));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_chosen_valid      <= res_valid;
      out_chosen_server     <= res_server;
      out_chosen_is_avoided <= res_avoided;
      out_map_length        <= wmlb_pkg::LEN_W'(total_in_use);
    end
  end

endmodule

@@ src/wmlb_ctrl.sv @@
// Controller: sequences set, rebuild, round-robin and hash commands.
module wmlb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wmlb_pkg::dp_status_t status,
  output wmlb_pkg::dp_cmd_t    cmd
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_DISPATCH  = 12'b000000000010,
    S_SUM       = 12'b000000000100,
    S_PREP      = 12'b000000001000,
    S_SCAN      = 12'b000000010000,
    S_SLOT_END  = 12'b000000100000,
    S_RR_READ   = 12'b000001000000,
    S_RR_CHECK  = 12'b000010000000,
    S_DIV       = 12'b000100000000,
    S_HASH_READ = 12'b001000000000,
    S_HASH_DATA = 12'b010000000000,
    S_FINISH    = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.res_clear = 1'b1;
        unique case (status.cmd_code)
          wmlb_pkg::CMD_SET: begin
            cmd.set_entry = 1'b1;
            state_next    = S_FINISH;
          end
          wmlb_pkg::CMD_REBUILD: begin
            cmd.sum_clear = 1'b1;
            state_next    = S_SUM;
          end
          wmlb_pkg::CMD_RR_PICK: begin
            cmd.rr_start = 1'b1;
            state_next   = status.total_zero ? S_FINISH : S_RR_READ;
          end
          wmlb_pkg::CMD_HASH_PICK: begin
            cmd.div_start = 1'b1;
            state_next    = status.total_zero ? S_FINISH : S_DIV;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_last) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.none_eligible ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = S_SLOT_END;
      end
      S_SLOT_END: begin
        cmd.slot_commit = 1'b1;
        state_next      = status.slot_last ? S_FINISH : S_SCAN;
      end
      S_RR_READ: begin
        cmd.rr_read = 1'b1;
        state_next  = S_RR_CHECK;
      end
      S_RR_CHECK: begin
        cmd.rr_check = 1'b1;
        state_next   = status.rr_stop ? S_FINISH : S_RR_READ;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_HASH_READ;
      end
      S_HASH_READ: begin
        cmd.hash_read = 1'b1;
        state_next    = S_HASH_DATA;
      end
      S_HASH_DATA: begin
        cmd.res_hash = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/weighted_map_load_balancer_top.sv @@
// Weighted slot-map load balancer: one request in, one result out per
// transfer. Commands run one at a time. A rebuild walks the server table
// once to sum weights, then fills each map slot with a scan over all servers,
// plus one extra scan step per extra multiple of the map length that a weight
// spans. A round-robin pick reads the single-port slot map one slot at a time
// from the saved index. A hash pick runs a bit-serial modulo over the 32-bit
// hash and reads one slot. Picks on an empty map skip the walk and the modulo.
// The finished result sits in an output register, so the next request is
// taken as soon as the result is handed off or waiting in that register.
module weighted_map_load_balancer_top #(
  parameter int SERVERS    = 16,
  parameter int MAX_WEIGHT = 256,
  parameter int MAP_DEPTH  = 4096
) (
  input logic         clk,
  input logic         rst,
  wmlb_req_if.sink    request,
  wmlb_rsp_if.source  result
);

  wmlb_pkg::dp_cmd_t    cmd;
  wmlb_pkg::dp_status_t status;

  wmlb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .status   (status),
    .cmd      (cmd)
  );

  wmlb_datapath #(
    .SERVERS    (SERVERS),
    .MAX_WEIGHT (MAX_WEIGHT),
    .MAP_DEPTH  (MAP_DEPTH)
  ) u_datapath (
    .clk                   (clk),
    .rst                   (rst),
    .command               (request.command),
    .server_index          (request.server_index),
    .weight                (request.weight),
    .backup                (request.backup),
    .usable                (request.usable),
    .available_mask        (request.available_mask),
    .avoid_index           (request.avoid_index),
    .hash                  (request.hash),
    .cmd                   (cmd),
    .status                (status),
    .out_ready             (result.ready),
    .out_valid             (result.valid),
    .out_chosen_valid      (result.chosen_valid),
    .out_chosen_server     (result.chosen_server),
    .out_chosen_is_avoided (result.chosen_is_avoided),
    .out_map_length        (result.map_length)
  );

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> !request.ready)
    else $error("request taken while a command is in flight");

  a_avoided_is_chosen: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.chosen_is_avoided |-> result.chosen_valid)
    else $error("avoided mark without a chosen server");

  a_no_choice_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.chosen_valid |->
      result.chosen_server == '0 && !result.chosen_is_avoided)
    else $error("empty pick carries a server");
`endif

endmodule

@@ tb/sv/wmlb_checker.sv @@
// Checker for the weighted map load balancer: predicts each result and compares.
`timescale 1ns / 1ps
module wmlb_checker #(
  parameter int SERVERS    = 16,
  parameter int MAX_WEIGHT = 256,
  parameter int MAP_DEPTH  = 4096
) (
  input  logic clk,
  input  logic rst,
  wmlb_req_if  request,
  wmlb_rsp_if  result,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic                       chosen_valid;
    logic [wmlb_pkg::SRV_W-1:0] chosen_server;
    logic                       chosen_is_avoided;
    logic [wmlb_pkg::LEN_W-1:0] map_length;
  } pick_t;

  int    srv_weight [SERVERS];
  bit    srv_backup [SERVERS];
  bit    srv_usable [SERVERS];
  int    score      [SERVERS];
  int    slot_owner [MAP_DEPTH];
  int    map_len;
  int    rotation;
  pick_t expected_picks[$];

  function automatic bit is_eligible(int i);
    return srv_usable[i] && srv_weight[i] != 0;
  endfunction

  function automatic void rebuild_slots();
    int act_w, bck_w, act_n, bck_n, tot, best, best_v, v;
    bit cls;
    act_w = 0; bck_w = 0; act_n = 0; bck_n = 0;
    for (int i = 0; i < SERVERS; i++) begin
      if (is_eligible(i)) begin
        if (srv_backup[i]) begin
          bck_w += srv_weight[i]; bck_n++;
        end else begin
          act_w += srv_weight[i]; act_n++;
        end
      end
    end
    cls = (act_n == 0);
    tot = act_n != 0 ? act_w : bck_w;
    if ((act_n == 0 && bck_n == 0) || tot == 0) begin
      map_len = 0;
      return;
    end
    if (tot > MAP_DEPTH) tot = MAP_DEPTH;
    map_len = tot;
    for (int i = 0; i < SERVERS; i++) score[i] = 0;
    for (int s = 0; s < tot; s++) begin
      best = -1;
      best_v = 0;
      for (int i = 0; i < SERVERS; i++) begin
        if (!is_eligible(i) || srv_backup[i] != cls) continue;
        if (tot == 1) begin
          best = i;
          break;
        end
        score[i] += srv_weight[i];
        v = (score[i] + tot) / tot;
        if (best < 0 || v > best_v) begin
          best_v = v;
          best = i;
        end
      end
      if (best < 0) best = 0;
      slot_owner[s] = best;
      if (tot != 1) score[best] -= tot;
    end
  endfunction

  function automatic pick_t predict_pick(wmlb_pkg::cmd_t cmd, int idx, int w, bit bk,
                                         bit us, logic [wmlb_pkg::MASK_W-1:0] mask,
                                         int avoid, logic [wmlb_pkg::HASH_W-1:0] h);
    pick_t p;
    int start, pos, srv, avoided_next, avoided_srv;
    bit found_avoided;
    p = '0;
    case (cmd)
      wmlb_pkg::CMD_SET: begin
        if (idx < SERVERS) begin
          srv_weight[idx] = w > MAX_WEIGHT ? MAX_WEIGHT : w;
          srv_backup[idx] = bk;
          srv_usable[idx] = us;
        end
      end
      wmlb_pkg::CMD_REBUILD: rebuild_slots();
      wmlb_pkg::CMD_RR_PICK: begin
        if (map_len != 0) begin
          start = rotation < map_len ? rotation : 0;
          pos = start;
          found_avoided = 0;
          avoided_next = 0;
          avoided_srv = 0;
          do begin
            srv = slot_owner[pos];
            pos++;
            if (pos == map_len) pos = 0;
            if (srv < 16 && mask[srv]) begin
              if (srv != avoid) begin
                rotation = pos;
                p.chosen_valid = 1;
                p.chosen_server = wmlb_pkg::SRV_W'(srv);
                break;
              end
              found_avoided = 1;
              avoided_next = pos;
              avoided_srv = srv;
            end
          end while (pos != start);
          if (!p.chosen_valid && found_avoided) begin
            rotation = avoided_next;
            p.chosen_valid = 1;
            p.chosen_server = wmlb_pkg::SRV_W'(avoided_srv);
            p.chosen_is_avoided = 1;
          end
        end
      end
      default: begin
        if (map_len != 0) begin
          p.chosen_valid = 1;
          p.chosen_server = wmlb_pkg::SRV_W'(slot_owner[longint'(h) % map_len]);
        end
      end
    endcase
    p.map_length = wmlb_pkg::LEN_W'(map_len);
    return p;
  endfunction

  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      for (int i = 0; i < SERVERS; i++) begin
        srv_weight[i] = 0; srv_backup[i] = 0; srv_usable[i] = 0; score[i] = 0;
      end
      map_len = 0;
      rotation = 0;
      errors = 0;
      expected_picks.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_picks.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors = errors + 1;
        end else begin
          want = expected_picks.pop_front();
          if (result.chosen_valid !== want.chosen_valid) begin
            $error("chosen_valid: expected %0d actual %0d", want.chosen_valid,
                   result.chosen_valid);
            errors = errors + 1;
          end
          if (result.chosen_server !== want.chosen_server) begin
            $error("chosen_server: expected %0d actual %0d", want.chosen_server,
                   result.chosen_server);
            errors = errors + 1;
          end
          if (result.chosen_is_avoided !== want.chosen_is_avoided) begin
            $error("chosen_is_avoided: expected %0d actual %0d",
                   want.chosen_is_avoided, result.chosen_is_avoided);
            errors = errors + 1;
          end
          if (result.map_length !== want.map_length) begin
            $error("map_length: expected %0d actual %0d", want.map_length,
                   result.map_length);
            errors = errors + 1;
          end
        end
      end
      if (request.valid && request.ready)
        expected_picks.push_back(predict_pick(wmlb_pkg::cmd_t'(request.command),
          request.server_index, request.weight, request.backup, request.usable,
          request.available_mask, request.avoid_index, request.hash));
    end
    pending = expected_picks.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench top: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int LIMIT = 300_000_000;

  logic clk = 0;
  logic rst = 1;
  int   errors, pending;
  int   cycles = 0;
  bit   calm;
  int   stall_left;

  wmlb_req_if request ();
  wmlb_rsp_if result ();

  weighted_map_load_balancer_top dut (.clk(clk), .rst(rst), .request(request),
                                      .result(result));
  wmlb_checker chk (.clk(clk), .rst(rst), .request(request), .result(result),
                    .errors(errors), .pending(pending));

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result-side stall bursts
  always @(posedge clk) begin
    if (calm || rst) begin
      result.ready <= 1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result.ready <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      result.ready <= 0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      result.ready <= 1;
    end
  end

  task automatic send(wmlb_pkg::cmd_t cmd, int idx, int w, bit bk, bit us, int mask,
                      int avoid, logic [31:0] h);
    if (!calm && $urandom_range(0, 4) == 0) begin
      request.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    request.valid          <= 1;
    request.command        <= cmd;
    request.server_index   <= wmlb_pkg::IDX_W'(idx);
    request.weight         <= wmlb_pkg::WGT_W'(w);
    request.backup         <= bk;
    request.usable         <= us;
    request.available_mask <= wmlb_pkg::MASK_W'(mask);
    request.avoid_index    <= wmlb_pkg::AVOID_W'(avoid);
    request.hash           <= h;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
  endtask

  task automatic set_entry(int idx, int w, bit bk, bit us);
    send(wmlb_pkg::CMD_SET, idx, w, bk, us, $urandom, $urandom_range(0, 31), $urandom);
  endtask

  task automatic pick(wmlb_pkg::cmd_t cmd, int mask, int avoid, logic [31:0] h);
    send(cmd, $urandom_range(0, 15), $urandom_range(0, 511), $urandom_range(0, 1) == 1,
         $urandom_range(0, 1) == 1, mask, avoid, h);
  endtask

  task automatic random_item();
    int r, mask;
    r = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0: mask = 0;
      1: mask = 16'hFFFF;
      2: mask = 1 << $urandom_range(0, 15);
      default: mask = $urandom_range(0, 16'hFFFF);
    endcase
    if (r < 40)
      set_entry($urandom_range(0, 15),
                $urandom_range(0, 24) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 6),
                $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0);
    else if (r < 52)
      pick(wmlb_pkg::CMD_REBUILD, mask, $urandom_range(0, 31), $urandom);
    else if (r < 80)
      pick(wmlb_pkg::CMD_RR_PICK, mask,
           $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 16),
           $urandom);
    else
      pick(wmlb_pkg::CMD_HASH_PICK, mask, $urandom_range(0, 31), $urandom);
  endtask

  initial begin
    request.valid <= 0;
    request.command <= wmlb_pkg::CMD_SET;
    request.server_index <= '0;
    request.weight <= '0;
    request.backup <= 0;
    request.usable <= 0;
    request.available_mask <= '0;
    request.avoid_index <= '0;
    request.hash <= '0;
    calm = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // empty map, nothing eligible
    pick(wmlb_pkg::CMD_RR_PICK, 16'hFFFF, 16, 0);
    pick(wmlb_pkg::CMD_HASH_PICK, 16'hFFFF, 16, 32'hFFFF_FFFF);
    set_entry(2, 0, 0, 1);
    pick(wmlb_pkg::CMD_REBUILD, 0, 16, 0);
    // single backup server, total of one; only the avoided one available
    set_entry(3, 1, 1, 1);
    pick(wmlb_pkg::CMD_REBUILD, 0, 16, 0);
    pick(wmlb_pkg::CMD_RR_PICK, 16'hFFFF, 3, 0);
    pick(wmlb_pkg::CMD_HASH_PICK, 0, 16, 32'hFFFF_FFFF);
    // saturated weight, active class wins over backup
    set_entry(15, 511, 0, 1);
    set_entry(0, 3, 0, 1);
    pick(wmlb_pkg::CMD_REBUILD, 0, 16, 0);
    pick(wmlb_pkg::CMD_RR_PICK, 0, 16, 0);
    pick(wmlb_pkg::CMD_RR_PICK, 1 << 15, 16, 0);
    pick(wmlb_pkg::CMD_RR_PICK, 16'hFFFF, 31, 0);
    pick(wmlb_pkg::CMD_RR_PICK, 16'hFFFF, 15, 0);
    set_entry(15, 256, 0, 0);
    pick(wmlb_pkg::CMD_REBUILD, 0, 16, 0);
    pick(wmlb_pkg::CMD_RR_PICK, 16'h0001, 0, 0);

    // full map: every server at the top weight
    for (int i = 0; i < 16; i++) set_entry(i, 256, 0, 1);
    pick(wmlb_pkg::CMD_REBUILD, 0, 16, 0);
    pick(wmlb_pkg::CMD_HASH_PICK, 0, 16, 32'hFFFF_FFFF);
    pick(wmlb_pkg::CMD_RR_PICK, 1 << 15, 16, 0);
    for (int i = 0; i < 16; i++)
      set_entry(i, $urandom_range(0, 6), $urandom_range(0, 3) == 0, 1);

    for (int n = 0; n < 1050; n++) begin
      if (n == 500) begin
        request.valid <= 0;
        while (pending != 0) @(posedge clk);
      end
      if (n == 900) calm = 1;
      random_item();
    end
    request.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
src/wmlb_pkg.sv
src/wmlb_req_if.sv
src/wmlb_rsp_if.sv
src/wmlb_datapath.sv
src/wmlb_ctrl.sv
src/weighted_map_load_balancer_top.sv
tb/sv/wmlb_checker.sv
tb/sv/testbench.sv
